// ----- rtl/core/wsrx_pkg.sv -----
// Shared types, codes and constants of the WebSocket receive deframer.
package wsrx_pkg;

  // Widths of the stream and register fields
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 24;
  localparam int unsigned EventW  = 3;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned CntW    = 3;
  localparam int unsigned ApbAw   = 3;
  localparam int unsigned ApbDw   = 32;
  localparam int unsigned TdataW  = ByteW + LenW;
  localparam int unsigned TuserW  = 1 + EventW;

  // Register reset values
  localparam logic [LenW-1:0] MaxPayloadRst = 24'd8388608;
  localparam logic [LenW-1:0] RecvBufRst    = 24'd4096;
  localparam logic [LenW-1:0] LenSat        = 24'hFF_FFFF;

  // Register index, taken from paddr bit 2
  localparam logic RegMaxPayload = 1'b0;
  localparam logic RegRecvBuf    = 1'b1;

  // Frame opcodes
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  // Short length codes in the second header byte
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  // Extended length and mask key byte counts
  localparam logic [CntW-1:0] Ext16Last = 3'd2;
  localparam logic [CntW-1:0] Ext64Last = 3'd0;
  localparam logic [CntW-1:0] KeyLast   = 3'd4;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EV_MID       = 3'd0,
    EV_TEXT_DONE = 3'd1,
    EV_FRAG      = 3'd2,
    EV_TOO_LARGE = 3'd3,
    EV_CLOSE     = 3'd4,
    EV_PING      = 3'd5,
    EV_OTHER     = 3'd6,
    EV_LEN_ERR   = 3'd7
  } event_e;

  // One result request
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             data_valid;
    logic             frame_end;
    event_e           event_res;
    logic [LenW-1:0]  frame_length;
  } res_t;

endpackage

// ----- rtl/core/websocket_rx_deframer.sv -----
// Top level of the WebSocket receive deframer: APB registers, frame parser, output skid.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata[7:0] rx_byte
//  m_axis    out  m_axis_tvalid/tready    tdata data_byte, frame_length; tuser; tlast
//  apb       in   psel/penable/pready     paddr[2:0], pwdata, prdata (32 bit)
//
// One byte is parsed per cycle while s_axis_tready is high; the parser state and the output
// register (or the skid slot when the output is stalled) both load at the accepting edge.
// The single skid slot lets the parser keep taking bytes for one result while the
// output is stalled; s_axis_tready drops only when both output slots are full.
// rst_ni clears the parser phase, flags and registers to their reset values at once.
module websocket_rx_deframer
  import wsrx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Slave side; tdata: rx_byte[7:0]
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ByteW-1:0]  s_axis_tdata,
  // Master side; tdata: data_byte[7:0], frame_length[31:8]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,
  // tuser: data_valid[0], event_res[3:1]
  output logic [TuserW-1:0] m_axis_tuser,
  // tlast: frame_end
  output logic              m_axis_tlast,
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ApbAw-1:0]  paddr,
  input  logic [ApbDw-1:0]  pwdata,
  output logic [ApbDw-1:0]  prdata,
  output logic              pready
);

  logic [LenW-1:0] max_q, rbs_q;
  logic            wr_en;

  phase_e          phase_q, phase_d;
  logic            fin_q, fin_d;
  logic [3:0]      opc_q, opc_d;
  logic            mask_q, mask_d;
  logic [LenW-1:0] len_q, len_d;
  logic            len_hi_q, len_hi_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic            closed_q, closed_d;
  logic            halted_q, halted_d;

  logic            accept;
  logic [ByteW-1:0] b;
  logic            len_done, hdr_done, finish;
  logic            fin_valid;
  logic [ByteW-1:0] fin_byte, key_byte, pay_byte;
  logic            last, deliver;
  event_e          end_ev;
  logic            res_valid;
  res_t            res, out_res;

  // APB register access
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxPayloadRst;
      rbs_q <= RecvBufRst;
    end else if (wr_en) begin
      if (paddr[2] == RegMaxPayload) begin
        max_q <= pwdata[LenW-1:0];
      end else begin
        rbs_q <= pwdata[LenW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegRecvBuf) ? {{(ApbDw-LenW){1'b0}}, rbs_q}
                                           : {{(ApbDw-LenW){1'b0}}, max_q};

  assign accept = s_axis_tvalid && s_axis_tready;
  assign b      = s_axis_tdata;

  // Pick the key byte for this payload position
  always_comb begin
    case (idx_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign pay_byte = mask_q ? (b ^ key_byte) : b;
  assign deliver  = (opc_q == OpText) && fin_q && (len_q < rbs_q);

  // Classify the end of the frame
  always_comb begin
    if (opc_q == OpText) begin
      if (!fin_q) begin
        end_ev = EV_FRAG;
      end else if (len_d >= rbs_q) begin
        end_ev = EV_TOO_LARGE;
      end else begin
        end_ev = EV_TEXT_DONE;
      end
    end else if (opc_q == OpClose) begin
      end_ev = EV_CLOSE;
    end else if (opc_q == OpPing) begin
      end_ev = EV_PING;
    end else begin
      end_ev = EV_OTHER;
    end
  end

  // Parse one byte: advance the header fields, unmask payload, build the request
  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    opc_d     = opc_q;
    mask_d    = mask_q;
    len_d     = len_q;
    len_hi_d  = len_hi_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    idx_d     = idx_q;
    closed_d  = closed_q;
    halted_d  = halted_q;
    len_done  = 1'b0;
    hdr_done  = 1'b0;
    finish    = 1'b0;
    fin_valid = 1'b0;
    fin_byte  = '0;
    last      = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (accept && !halted_q && !closed_q) begin
      case (phase_q)
        PH_HDR0: begin
          fin_d   = b[7];
          opc_d   = b[3:0];
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d   = b[7];
          key_d    = '0;
          cnt_d    = '0;
          len_hi_d = 1'b0;
          len_d    = '0;
          if (b[6:0] == Len16Code) begin
            phase_d = PH_EXT16;
          end else if (b[6:0] == Len64Code) begin
            phase_d = PH_EXT64;
          end else begin
            len_d    = {{(LenW-7){1'b0}}, b[6:0]};
            len_done = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          // bytes pushed past the low 24 bits only matter as nonzero
          len_hi_d = len_hi_q || (len_q[LenW-1:LenW-ByteW] != '0);
          len_d    = {len_q[LenW-ByteW-1:0], b};
          cnt_d    = cnt_q + 3'd1;
          if (cnt_d == ((phase_q == PH_EXT16) ? Ext16Last : Ext64Last)) begin
            len_done = 1'b1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[KeyW-ByteW-1:0], b};
          cnt_d = cnt_q + 3'd1;
          if (cnt_d == KeyLast) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          idx_d = idx_q + 24'd1;
          last  = idx_d >= len_q;
          if (deliver) begin
            if (last) begin
              finish    = 1'b1;
              fin_valid = 1'b1;
              fin_byte  = pay_byte;
            end else begin
              res_valid        = 1'b1;
              res.data_byte    = pay_byte;
              res.data_valid   = 1'b1;
              res.event_res    = EV_MID;
              res.frame_length = len_q;
            end
          end else if (last) begin
            finish = 1'b1;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      // Length complete: go to the mask key or close the header
      if (len_done) begin
        cnt_d = '0;
        if (mask_d) begin
          phase_d = PH_MASK;
        end else begin
          hdr_done = 1'b1;
        end
      end

      // Header complete: check the length, then report a length error and halt, or start or end the payload
      if (hdr_done) begin
        if (len_hi_d || (len_d > max_q)) begin
          res_valid        = 1'b1;
          res.frame_end    = 1'b1;
          res.event_res    = EV_LEN_ERR;
          res.frame_length = len_hi_d ? LenSat : len_d;
          halted_d         = 1'b1;
          phase_d          = PH_HDR0;
        end else begin
          idx_d = '0;
          if (len_d == '0) begin
            finish = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end

      // Frame end request
      if (finish) begin
        res_valid        = 1'b1;
        res.data_byte    = fin_byte;
        res.data_valid   = fin_valid;
        res.frame_end    = 1'b1;
        res.event_res    = end_ev;
        res.frame_length = len_d;
        phase_d          = PH_HDR0;
        if (opc_q == OpClose) begin
          closed_d = 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      fin_q    <= 1'b0;
      opc_q    <= '0;
      mask_q   <= 1'b0;
      len_q    <= '0;
      len_hi_q <= 1'b0;
      cnt_q    <= '0;
      key_q    <= '0;
      idx_q    <= '0;
      closed_q <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      opc_q    <= opc_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      len_hi_q <= len_hi_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      closed_q <= closed_d;
      halted_q <= halted_d;
    end
  end

  wsrx_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_res_i  (res),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {out_res.frame_length, out_res.data_byte};
  assign m_axis_tuser = {out_res.event_res, out_res.data_valid};
  assign m_axis_tlast = out_res.frame_end;

`ifndef SYNTHESIS
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared without reset");

  a_payload_len_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> !len_hi_q)
    else $error("payload phase entered with an oversized length");

  a_data_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.data_valid) |->
      (res.event_res == EV_MID || res.event_res == EV_TEXT_DONE))
    else $error("text byte delivered with a non-text event");

  a_end_matches_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res.frame_end == (res.event_res != EV_MID)))
    else $error("frame end flag disagrees with event");

  a_idle_when_stopped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted_q || closed_q) |-> !res_valid)
    else $error("result request after the block stopped");
`endif

endmodule

// ----- rtl/core/wsrx_out_skid.sv -----
// Output register with one skid slot for the deframer result stream.
module wsrx_out_skid
  import wsrx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_res_i,
  output logic ready_o,
  output logic out_valid_o,
  output res_t out_res_o,
  input  logic out_ready_i
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;

  // Refill the output stage from the skid slot first, park a request when stalled
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = push_res_i;
      end else begin
        out_valid_d = push_i;
        out_d       = push_res_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_res_i;
    end
  end

  // Clear valid flags under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef SYNTHESIS
  a_skid_implies_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while output stage empty");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_valid_q && !out_ready_i) |-> !push_i)
    else $error("result request pushed into a full skid");
`endif

endmodule
